@@ rtl/ttw_pkg.sv @@
// ----------------------------------------------------------------------------
// ttw_pkg
// types and constants shared by the text terminal writer modules
// ----------------------------------------------------------------------------
package ttw_pkg;

    localparam logic [2:0] ACT_PRINT = 3'd0;
    localparam logic [2:0] ACT_PUT   = 3'd1;
    localparam logic [2:0] ACT_SETC  = 3'd2;
    localparam logic [2:0] ACT_CLEAR = 3'd3;
    localparam logic [2:0] ACT_READ  = 3'd4;

    localparam logic [7:0] CH_NEWLINE   = 8'h0A;
    localparam logic [7:0] CH_RETURN    = 8'h0D;
    localparam logic [7:0] CH_BACKSPACE = 8'h08;
    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_SPACE     = 8'h20;

    // memory access request from the sequencer
    typedef struct packed {
        logic        wr_en;
        logic [12:0] wr_addr;
        logic [15:0] wr_data;
        logic        rd_en;
        logic [12:0] rd_addr;
    } mem_req_t;

endpackage

@@ rtl/ttw_cell_ram.sv @@
// ----------------------------------------------------------------------------
// ttw_cell_ram
// screen cell memory, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module ttw_cell_ram
    import ttw_pkg::*;
#(
    parameter int DEPTH = 2000,
    parameter int AW = 11
)
(
    input  logic        clk,
    input  mem_req_t    req,
    output logic [15:0] rd_data
);

    logic [15:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr[AW-1:0]] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rd_data <= mem[req.rd_addr[AW-1:0]];
        end
    end

endmodule

@@ rtl/text_terminal_writer.sv @@
// ----------------------------------------------------------------------------
// text_terminal_writer
// character-cell terminal engine over a screen cell memory
// ----------------------------------------------------------------------------
// s_axis carries one action per item; m_axis returns one result per item with
// the linear cursor position, the read cell value and a scroll flag.
// text_color is written through cfg_we/cfg_wdata; the user must do so only while
// the block is idle, and the block itself does not enforce this. An item is
// accepted in the idle state and passes through ST_OUT, on leaving which its
// result is registered (a read first passes through ST_READ, which waits on the
// registered memory read). The input stays closed until that result is taken,
// so the block takes no new item before the last one is through.
// A scroll walks the cell memory, one read and one write per moved cell plus
// one write per blank cell. A clear writes one cell a cycle. Both run through
// the single cell memory port pair.
// The result sits in an output register; while m_axis_tready is low the
// block holds it and accepts no new item. Reset puts the cursor at 0,0 and
// text_color at 15; the cell memory is undefined until written.
// ----------------------------------------------------------------------------
module text_terminal_writer
    import ttw_pkg::*;
#(
    parameter int COLUMNS = 80,
    parameter int ROWS = 25,
    parameter int TAB_STOP = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // action[2:0], character[10:3], column[17:11], row[22:18], cell_color[30:23]
    input  logic [31:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // cursor_position[10:0], cell_value[26:11], scrolled[27]
    output logic [31:0] m_axis_tdata
);

    localparam int CELLS = COLUMNS * ROWS;
    localparam int AW = $clog2(CELLS);
    localparam int LAST_ROW_BASE = (ROWS - 1) * COLUMNS;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_READ  = 3'd1;
    localparam logic [2:0] ST_CLEAR = 3'd2;
    localparam logic [2:0] ST_SRD   = 3'd3;
    localparam logic [2:0] ST_SWR   = 3'd4;
    localparam logic [2:0] ST_BLANK = 3'd5;
    localparam logic [2:0] ST_OUT   = 3'd6;

    logic [2:0]  state_reg, state_next;
    logic [6:0]  ccol_reg, ccol_next;
    logic [5:0]  crow_reg, crow_next;
    logic [7:0]  color_reg;
    logic [AW-1:0] ptr_reg, ptr_next;
    logic [10:0] pos_reg, pos_next;
    logic [15:0] val_reg, val_next;
    logic        scr_reg, scr_next;
    logic        ovalid_reg, ovalid_next;
    logic        rd_sel_reg, rd_sel_next;
    mem_req_t    req;
    logic [15:0] rd_data;

    logic [2:0]  in_action;
    logic [7:0]  in_char;
    logic [6:0]  in_col;
    logic [4:0]  in_row;
    logic [7:0]  in_color;
    logic        in_ok;
    logic [AW-1:0] in_addr, cur_addr;
    logic [7:0]  ncol;
    logic [6:0]  nrow;

    // smallest tab stop past the column, by compares against constants
    function automatic logic [7:0] next_tab(logic [6:0] c);
        logic [7:0] t;
        t = 8'd0;
        for (int k = 128 / TAB_STOP + 1; k >= 1; k--)
        begin
            if (32'(c) < k * TAB_STOP)
            begin
                t = 8'(k * TAB_STOP);
            end
        end
        return t;
    endfunction

    assign in_action = s_axis_tdata[2:0];
    assign in_char   = s_axis_tdata[10:3];
    assign in_col    = s_axis_tdata[17:11];
    assign in_row    = s_axis_tdata[22:18];
    assign in_color  = s_axis_tdata[30:23];
    assign in_ok     = (32'(in_col) < COLUMNS) && (32'(in_row) < ROWS);
    assign in_addr   = AW'(32'(in_row) * COLUMNS + 32'(in_col));
    assign cur_addr  = AW'(32'(crow_reg) * COLUMNS + 32'(ccol_reg));

    assign s_axis_tready = (state_reg == ST_IDLE) && !ovalid_reg;
    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata  = {4'd0, scr_reg, val_reg, pos_reg};

    ttw_cell_ram #(.DEPTH(CELLS), .AW(AW)) u_ram (
        .clk     (clk),
        .req     (req),
        .rd_data (rd_data)
    );

    always_comb
    begin
        state_next  = state_reg;
        ccol_next   = ccol_reg;
        crow_next   = crow_reg;
        ptr_next    = ptr_reg;
        pos_next    = pos_reg;
        val_next    = val_reg;
        scr_next    = scr_reg;
        ovalid_next = ovalid_reg;
        rd_sel_next = 1'b0;
        req         = '0;
        ncol        = {1'b0, ccol_reg};
        nrow        = {1'b0, crow_reg};
        if (ovalid_reg && m_axis_tready)
        begin
            ovalid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid && s_axis_tready)
                begin
                    val_next = '0;
                    scr_next = 1'b0;
                    state_next = ST_OUT;
                    unique case (in_action)
                        ACT_PRINT:
                        begin
                            priority case (in_char)
                                CH_NEWLINE:
                                begin
                                    ncol = '0;
                                    nrow = nrow + 7'd1;
                                end
                                CH_RETURN:
                                begin
                                    ncol = '0;
                                end
                                CH_BACKSPACE:
                                begin
                                    if (ccol_reg != '0)
                                    begin
                                        ncol = ncol - 8'd1;
                                        req.wr_en = 1'b1;
                                        req.wr_addr = 13'(cur_addr) - 13'd1;
                                        req.wr_data = {color_reg, CH_SPACE};
                                    end
                                end
                                CH_TAB:
                                begin
                                    ncol = next_tab(ccol_reg);
                                end
                                default:
                                begin
                                    req.wr_en = 1'b1;
                                    req.wr_addr = 13'(cur_addr);
                                    req.wr_data = {color_reg, in_char};
                                    ncol = ncol + 8'd1;
                                end
                            endcase
                            if (32'(ncol) >= COLUMNS)
                            begin
                                ncol = '0;
                                nrow = nrow + 7'd1;
                            end
                            if (32'(nrow) >= ROWS)
                            begin
                                nrow = 7'(ROWS - 1);
                                scr_next = 1'b1;
                                ptr_next = '0;
                                state_next = ST_SRD;
                            end
                            ccol_next = ncol[6:0];
                            crow_next = nrow[5:0];
                        end
                        ACT_PUT:
                        begin
                            req.wr_en = in_ok;
                            req.wr_addr = 13'(in_addr);
                            req.wr_data = {in_color, in_char};
                        end
                        ACT_SETC:
                        begin
                            ccol_next = (32'(in_col) < COLUMNS) ? in_col : 7'(COLUMNS - 1);
                            crow_next = (32'(in_row) < ROWS) ? 6'(in_row) : 6'(ROWS - 1);
                        end
                        ACT_CLEAR:
                        begin
                            ccol_next = '0;
                            crow_next = '0;
                            ptr_next = '0;
                            state_next = ST_CLEAR;
                        end
                        ACT_READ:
                        begin
                            req.rd_en = 1'b1;
                            req.rd_addr = 13'(in_addr);
                            rd_sel_next = in_ok;
                            state_next = ST_READ;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_READ:
            begin
                val_next = rd_sel_reg ? rd_data : 16'd0;
                state_next = ST_OUT;
            end
            ST_CLEAR:
            begin
                req.wr_en = 1'b1;
                req.wr_addr = 13'(ptr_reg);
                req.wr_data = {color_reg, CH_SPACE};
                ptr_next = ptr_reg + AW'(1);
                if (32'(ptr_reg) == CELLS - 1)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_SRD:
            begin
                // fetch the cell one row below
                req.rd_en = 1'b1;
                req.rd_addr = 13'(ptr_reg) + 13'(COLUMNS);
                state_next = ST_SWR;
            end
            ST_SWR:
            begin
                req.wr_en = 1'b1;
                req.wr_addr = 13'(ptr_reg);
                req.wr_data = rd_data;
                ptr_next = ptr_reg + AW'(1);
                state_next = (32'(ptr_reg) == LAST_ROW_BASE - 1) ? ST_BLANK : ST_SRD;
            end
            ST_BLANK:
            begin
                req.wr_en = 1'b1;
                req.wr_addr = 13'(ptr_reg);
                req.wr_data = {color_reg, CH_SPACE};
                ptr_next = ptr_reg + AW'(1);
                if (32'(ptr_reg) == CELLS - 1)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                pos_next = 11'(32'(crow_reg) * COLUMNS + 32'(ccol_reg));
                ovalid_next = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            ccol_reg   <= '0;
            crow_reg   <= '0;
            color_reg  <= 8'd15;
            ovalid_reg <= 1'b0;
            rd_sel_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            ccol_reg   <= ccol_next;
            crow_reg   <= crow_next;
            ovalid_reg <= ovalid_next;
            rd_sel_reg <= rd_sel_next;
            if (cfg_we)
            begin
                color_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg <= ptr_next;
        pos_reg <= pos_next;
        val_reg <= val_next;
        scr_reg <= scr_next;
    end

    a_cursor_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (32'(ccol_reg) < COLUMNS) && (32'(crow_reg) < ROWS))
        else $error("cursor off screen");

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !s_axis_tready)
        else $error("item accepted while busy");

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_OUT) |=> m_axis_tvalid)
        else $error("result not presented");

    a_no_dual_mem: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR || state_reg == ST_BLANK) |-> !req.rd_en)
        else $error("read during fill");

endmodule
